// ----- design/mrci_pkg.sv -----
// Package for the mask ring classifier / indexer.
// Holds the class codes, result record, register map and fixed field widths.
// No dependencies.
`default_nettype none

package mrci_pkg;

	localparam int PIX_W      = 8;
	localparam int IDX_W      = 20;
	localparam int NEXT_W     = 21;
	localparam int CFG_W      = 11;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;
	localparam int REG_LSB    = 2;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;

	localparam logic [CFG_W-1:0] RESET_SIZE = 11'd1024;

	// register index as decoded from paddr
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		CLS_NONE   = 2'd0,
		CLS_RING   = 2'd1,
		CLS_OPAQUE = 2'd2
	} pix_class_t;

	// held pixel flags
	typedef struct packed {
		logic left;
		logic vert;
		logic opaque;
		logic valid;
	} pend_t;

	typedef struct packed {
		pix_class_t        pixel_class;
		logic [IDX_W-1:0]  unknown_index;
		logic              frame_done;
		logic              last;
	} result_t;

endpackage

`default_nettype wire

// ----- design/mrci_if.sv -----
// Request channel interfaces for the mask ring classifier / indexer.
// mrci_in_if carries pixel alphas, mrci_out_if carries results; uses mrci_pkg.
`default_nettype none

interface mrci_in_if;
	import mrci_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] alpha_here;
	logic [PIX_W-1:0] alpha_below;

	modport source (output valid, output alpha_here, output alpha_below, input ready);
	modport sink   (input valid, input alpha_here, input alpha_below, output ready);
endinterface

interface mrci_out_if;
	import mrci_pkg::*;

	logic             valid;
	logic             ready;
	pix_class_t       pixel_class;
	logic [IDX_W-1:0] unknown_index;
	logic             frame_done;
	logic             last;

	modport source (output valid, output pixel_class, output unknown_index,
		output frame_done, output last, input ready);
	modport sink   (input valid, input pixel_class, input unknown_index,
		input frame_done, input last, output ready);
endinterface

`default_nettype wire

// ----- design/mrci_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Read-first: a read and a write of the same address in one cycle return the old data.
`default_nettype none

module mrci_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- design/mask_ring_classifier_indexer.sv -----
// Mask ring classifier / indexer top level; uses mrci_pkg, mrci_if, mrci_ram.
// Throughput: one pixel request per cycle while the queue has room, set by the line buffer
//   (one read, one write each). The request that releases a result (the right neighbour,
//   or the pixel itself at row end) is registered into stage 1, which queues that result.
// Reset: frame width and height go to 1024, counters, held pixel and index go to zero;
//   the line buffer is not cleared, the first row of a frame ignores what it reads.
`default_nettype none

module mask_ring_classifier_indexer #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	mrci_in_if.sink                             pix_in,
	mrci_out_if.source                          pix_out,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mrci_pkg::APB_AW-1:0]    paddr,
	input  wire logic [mrci_pkg::APB_DW-1:0]    pwdata,
	output logic      [mrci_pkg::APB_DW-1:0]    prdata,
	output logic                                pready
);
	import mrci_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int XW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int YW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
	localparam int QW = FIFO_AW + 2;

	// configuration
	logic [CFG_W-1:0] width_q, height_q;
	logic             cfg_wr;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[REG_LSB];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_SIZE;
			height_q <= RESET_SIZE;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_FRAME_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_FRAME_WIDTH:  prdata = APB_DW'(width_q);
			REG_FRAME_HEIGHT: prdata = APB_DW'(height_q);
			default:          prdata = '0;
		endcase
	end

	logic [XW-1:0] w_eff;
	logic [YW-1:0] h_eff;

	always_comb begin
		if (width_q == '0) begin
			w_eff = XW'(1);
		end else if (XW'(width_q) > XW'(MAX_WIDTH)) begin
			w_eff = XW'(MAX_WIDTH);
		end else begin
			w_eff = XW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = YW'(1);
		end else if (YW'(height_q) > YW'(MAX_HEIGHT)) begin
			h_eff = YW'(MAX_HEIGHT);
		end else begin
			h_eff = YW'(height_q);
		end
	end

	// stage 0: position counters and line buffer access
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          accept;
	logic          row_end, last_row, here_op, below_op;
	logic          above_raw;

	assign accept   = pix_in.valid & pix_in.ready;
	assign row_end  = (XW'(col_q) + XW'(1)) >= w_eff;
	assign last_row = (YW'(row_q) + YW'(1)) >= h_eff;
	assign here_op  = |pix_in.alpha_here;
	assign below_op = !last_row && (|pix_in.alpha_below);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// read-first RAM: this request reads the previous row's bit and overwrites it
	mrci_ram #(
		.WIDTH(1),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (accept),
		.waddr(col_q),
		.wdata(here_op),
		.raddr(col_q),
		.rdata(above_raw)
	);

	logic valid_s1;
	logic here_op_s1, below_op_s1, row_nz_s1, col_nz_s1, row_end_s1, frame_end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			here_op_s1   <= here_op;
			below_op_s1  <= below_op;
			row_nz_s1    <= row_q != '0;
			col_nz_s1    <= col_q != '0;
			row_end_s1   <= row_end;
			frame_end_s1 <= row_end & last_row;
		end
	end

	// stage 1: classify held and current pixel, assign indices
	pend_t             pending_q, cur;
	logic [NEXT_W-1:0] next_index_q, ni1, ni2;
	logic              emit_left, emit_cur;
	pix_class_t        cls_a, cls_b;
	result_t           res_a, res_b;

	assign emit_left = valid_s1 & pending_q.valid & col_nz_s1;
	assign emit_cur  = valid_s1 & row_end_s1;

	always_comb begin
		cur.valid  = 1'b1;
		cur.opaque = here_op_s1;
		cur.vert   = (row_nz_s1 & above_raw) | below_op_s1;
		cur.left   = emit_left & pending_q.opaque;

		if (pending_q.opaque) begin
			cls_a = CLS_OPAQUE;
		end else if (pending_q.vert | pending_q.left | here_op_s1) begin
			cls_a = CLS_RING;
		end else begin
			cls_a = CLS_NONE;
		end
		ni1 = next_index_q + NEXT_W'(emit_left && cls_a != CLS_NONE);

		if (cur.opaque) begin
			cls_b = CLS_OPAQUE;
		end else if (cur.vert | cur.left) begin
			cls_b = CLS_RING;
		end else begin
			cls_b = CLS_NONE;
		end
		ni2 = ni1 + NEXT_W'(cls_b != CLS_NONE);

		res_a.pixel_class   = cls_a;
		res_a.unknown_index = (cls_a != CLS_NONE) ? next_index_q[IDX_W-1:0] : '0;
		res_a.frame_done    = 1'b0;
		res_a.last          = !row_end_s1;

		res_b.pixel_class   = cls_b;
		res_b.unknown_index = (cls_b != CLS_NONE) ? ni1[IDX_W-1:0] : '0;
		res_b.frame_done    = frame_end_s1;
		res_b.last          = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			next_index_q <= '0;
		end else if (valid_s1) begin
			if (row_end_s1) begin
				pending_q    <= '0;
				next_index_q <= frame_end_s1 ? '0 : ni2;
			end else begin
				pending_q    <= cur;
				next_index_q <= ni1;
			end
		end
	end

	// output queue
	result_t            fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QW-1:0]      cnt_q, push_n;
	logic               pop;

	assign push_n = QW'(emit_left) + QW'(emit_cur);
	assign pop    = pix_out.valid & pix_out.ready;

	// admit a request only if the queue can take both results it may cause
	assign pix_in.ready = (cnt_q + push_n + QW'(2)) <= QW'(FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[FIFO_AW-1:0];
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			cnt_q    <= cnt_q + push_n - QW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (emit_left) begin
			fifo_q[wr_ptr_q] <= res_a;
			if (emit_cur) begin
				fifo_q[wr_ptr_q + FIFO_AW'(1)] <= res_b;
			end
		end else if (emit_cur) begin
			fifo_q[wr_ptr_q] <= res_b;
		end
	end

	assign pix_out.valid         = cnt_q != '0;
	assign pix_out.pixel_class   = fifo_q[rd_ptr_q].pixel_class;
	assign pix_out.unknown_index = fifo_q[rd_ptr_q].unknown_index;
	assign pix_out.frame_done    = fifo_q[rd_ptr_q].frame_done;
	assign pix_out.last          = fifo_q[rd_ptr_q].last;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QW'(FIFO_DEPTH))
		else $error("output queue overfilled");

	a_frame_index_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && frame_end_s1 |=> next_index_q == '0)
		else $error("index not cleared at frame end");

	a_row_end_flush: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && row_end_s1 |=> !pending_q.valid)
		else $error("held pixel survives row end");

	a_none_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && pix_out.pixel_class == CLS_NONE |-> pix_out.unknown_index == '0)
		else $error("untouched pixel carries an index");

endmodule

`default_nettype wire
